// ===== hw/rtl/sma_pkg.sv =====
// ----------------------------------------------------------------------------
// sma_pkg: shared definitions for the simple moving average
// Holds the controller state type, input mode codes and register constants.
// ----------------------------------------------------------------------------
package sma_pkg;

  // Width and reset value of the window size register.
  localparam int unsigned CFG_WIDTH         = 9;
  localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = 9'd16;

  // Input mode codes.
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_DIV,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/sma_in_if.sv =====
// ----------------------------------------------------------------------------
// sma_in_if: input channel of the moving average
// Carries one sample or clear request per transfer.
// ----------------------------------------------------------------------------
interface sma_in_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output mode, output sample, input ready);
  modport sink   (input valid, input mode, input sample, output ready);
endinterface

// ===== hw/rtl/sma_out_if.sv =====
// ----------------------------------------------------------------------------
// sma_out_if: result channel of the moving average
// Carries one average and the settled flag per transfer.
// ----------------------------------------------------------------------------
interface sma_out_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] average;
  logic                           settled;

  modport source (output valid, output average, output settled, input ready);
  modport sink   (input valid, input average, input settled, output ready);
endinterface

// ===== hw/rtl/simple_moving_average.sv =====
// No new sample is taken until the bit-serial divider is done and its result has entered the output register.
// A clear transfer gives no result.
// Reset (rst, synchronous) clears index, sum, window-full flag and the output valid flag;
// the window size returns to 16. The sample ring keeps undefined contents.
// ----------------------------------------------------------------------------
// simple_moving_average: moving average with warm-up
// Sample ring in a synchronous memory, a running sum, and a restoring divider
// that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module simple_moving_average #(
  parameter int unsigned WINDOW_MAX   = 256,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sma_pkg::CFG_WIDTH-1:0] cfg_data,
  sma_in_if.sink                        samples,
  sma_out_if.source                     results
);

  localparam int unsigned IDX_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CNT_W   = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SUM_W   = SAMPLE_WIDTH + CNT_W;
  localparam int unsigned STEP_W  = $clog2(SUM_W);
  localparam int unsigned CMP_W   = (CNT_W > sma_pkg::CFG_WIDTH) ? CNT_W
                                                                   : sma_pkg::CFG_WIDTH;
  localparam logic [SUM_W-1:0] HI_MAG = (SUM_W'(1) << (SAMPLE_WIDTH - 1)) - SUM_W'(1);
  localparam logic [SUM_W-1:0] LO_MAG = SUM_W'(1) << (SAMPLE_WIDTH - 1);

  sma_pkg::state_t state, state_next;

  logic [sma_pkg::CFG_WIDTH-1:0]  window_size;
  logic [IDX_W-1:0]               write_index;
  logic signed [SUM_W-1:0]        running_sum;
  logic                           window_full;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;

  logic signed [SAMPLE_WIDTH-1:0] ring [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] rd_data;

  logic [CNT_W-1:0]  divisor;
  logic [CNT_W-1:0]  rem;
  logic [SUM_W-1:0]  quo;
  logic              neg;
  logic [STEP_W-1:0] step;

  logic                           out_valid;
  logic signed [SAMPLE_WIDTH-1:0] out_average;
  logic                           out_settled;

  logic                    in_fire;
  logic                    out_free;
  logic [CNT_W-1:0]        n_eff;
  logic [CMP_W-1:0]        ws_ext;
  logic [CNT_W-1:0]        idx_inc;
  logic signed [SUM_W-1:0] sum_new;
  logic signed [SUM_W-1:0] old_ext;
  logic signed [SUM_W-1:0] new_ext;
  logic [CNT_W:0]          trial;
  logic [SAMPLE_WIDTH-1:0] avg_sat;
  logic [SUM_W-1:0]        quo_neg;

  // Handshakes.
  assign samples.ready   = (state == sma_pkg::S_IDLE);
  assign in_fire         = samples.valid && samples.ready;
  assign out_free        = !out_valid || results.ready;
  assign results.valid   = out_valid;
  assign results.average = out_average;
  assign results.settled = out_settled;

  // Effective window size, with zero read as one and oversize clamped.
  always_comb begin
    ws_ext = CMP_W'(window_size);
    if (ws_ext == '0) begin
      n_eff = CNT_W'(1);
    end else if (ws_ext > CMP_W'(WINDOW_MAX)) begin
      n_eff = CNT_W'(WINDOW_MAX);
    end else begin
      n_eff = ws_ext[CNT_W-1:0];
    end
  end

  // Sum update: the oldest sample leaves only once the window is full.
  always_comb begin
    old_ext = window_full ? {{(SUM_W-SAMPLE_WIDTH){rd_data[SAMPLE_WIDTH-1]}}, rd_data}
                          : '0;
    new_ext = {{(SUM_W-SAMPLE_WIDTH){sample_q[SAMPLE_WIDTH-1]}}, sample_q};
    sum_new = running_sum - old_ext + new_ext;
    idx_inc = CNT_W'(write_index) + CNT_W'(1);
  end

  // One restoring division step.
  assign trial = {rem, quo[SUM_W-1]};

  // Saturate the signed quotient to the sample range.
  always_comb begin
    quo_neg = -quo;
    if (neg) begin
      avg_sat = (quo > LO_MAG) ? LO_MAG[SAMPLE_WIDTH-1:0] : quo_neg[SAMPLE_WIDTH-1:0];
    end else begin
      avg_sat = (quo > HI_MAG) ? HI_MAG[SAMPLE_WIDTH-1:0] : quo[SAMPLE_WIDTH-1:0];
    end
  end

  // Sample ring: a write in the sum state and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (state == sma_pkg::S_SUM) begin
      ring[write_index] <= sample_q;
    end
    rd_data <= ring[write_index];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sma_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      sma_pkg::S_IDLE: begin
        if (in_fire && samples.mode == sma_pkg::MODE_SAMPLE) begin
          state_next = sma_pkg::S_SUM;
        end
      end
      sma_pkg::S_SUM: begin
        state_next = sma_pkg::S_DIV;
      end
      sma_pkg::S_DIV: begin
        if (step == '0) begin
          state_next = sma_pkg::S_DONE;
        end
      end
      sma_pkg::S_DONE: begin
        if (out_free) begin
          state_next = sma_pkg::S_IDLE;
        end
      end
      default: state_next = sma_pkg::S_IDLE;
    endcase
  end

  // Window state, configuration and sample capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= sma_pkg::WINDOW_SIZE_RESET;
      write_index <= '0;
      running_sum <= '0;
      window_full <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_size <= cfg_data;
      end
      if (in_fire && samples.mode == sma_pkg::MODE_CLEAR) begin
        write_index <= '0;
        running_sum <= '0;
        window_full <= 1'b0;
      end
      if (state == sma_pkg::S_SUM) begin
        running_sum <= sum_new;
        if (idx_inc >= n_eff) begin
          write_index <= '0;
          window_full <= 1'b1;
        end else begin
          write_index <= idx_inc[IDX_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_q <= samples.sample;
    end
  end

  // Divider datapath: magnitude of the sum over the divisor, MSB first.
  always_ff @(posedge clk) begin
    if (state == sma_pkg::S_SUM) begin
      divisor <= window_full ? n_eff : idx_inc;
      neg     <= sum_new[SUM_W-1];
      quo     <= sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
      rem     <= '0;
      step    <= STEP_W'(SUM_W - 1);
    end else if (state == sma_pkg::S_DIV) begin
      if (trial >= {1'b0, divisor}) begin
        rem <= CNT_W'(trial - {1'b0, divisor});
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[CNT_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
      step <= step - STEP_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == sma_pkg::S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == sma_pkg::S_DONE && out_free) begin
      out_average <= avg_sat;
      out_settled <= window_full;
    end
  end

`ifndef NO_ASSERTIONS
  // During division the partial remainder stays below a nonzero divisor.
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    state == sma_pkg::S_DIV |-> (rem < divisor && divisor != '0))
    else $error("divider remainder not below divisor");

  // A clear transfer empties the window state.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (in_fire && samples.mode == sma_pkg::MODE_CLEAR) |=>
      (running_sum == '0 && write_index == '0 && !window_full))
    else $error("clear did not reset window state");

  // A new result is only loaded on leaving the final state.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid && !results.ready)) |-> $past(state == sma_pkg::S_DONE))
    else $error("result loaded outside the final state");

  // A sample transfer starts the sum update in the next cycle.
  a_sample_start: assert property (@(posedge clk) disable iff (rst)
    (in_fire && samples.mode == sma_pkg::MODE_SAMPLE) |=> state == sma_pkg::S_SUM)
    else $error("sample transfer did not start processing");
`endif

endmodule
